### rtl/ptve_pkg.sv
// Shared types and constants for the pose transform and velocity estimator.
package ptve_pkg;

  // Fixed-point scale factors.
  localparam logic signed [32:0] DEG_TO_RAD_Q32 = 33'sd74961321;
  localparam logic signed [32:0] MS_PER_S       = 33'sd1000;

  // Widths of the rate divider: scaled magnitude and quotient.
  localparam int NUM_W = 42;
  localparam int QUO_W = 31;
  localparam int CNT_W = 5;

  // Configuration register indexes.
  localparam logic [2:0] REG_COS     = 3'd0;
  localparam logic [2:0] REG_SIN     = 3'd1;
  localparam logic [2:0] REG_X_OFF   = 3'd2;
  localparam logic [2:0] REG_Y_OFF   = 3'd3;
  localparam logic [2:0] REG_HDG_OFF = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_XC,
    S_YS,
    S_XS,
    S_YC,
    S_DEG,
    S_FIN_Y,
    S_FIN_H,
    S_DIFF,
    S_MUL,
    S_NUM,
    S_WAIT,
    S_DONE
  } state_t;

  // Velocity channel being worked on.
  typedef enum logic [1:0] {
    CH_X,
    CH_Y,
    CH_H
  } chan_t;

  // Status from the rate divider.
  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

### rtl/ptve_div.sv
// Restoring divider that forms one saturating velocity quotient, one bit a cycle.
module ptve_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ptve_pkg::NUM_W-1:0] num,
  input  logic [31:0]              dt,
  output ptve_pkg::div_stat_t      stat,
  output logic [ptve_pkg::QUO_W-1:0] quo
);
  import ptve_pkg::*;

  logic [31:0]      rem;
  logic [QUO_W-1:0] low;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             sat;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             ge;
  logic             pre_sat;

  // The quotient overflows 31 bits exactly when the top bits of the numerator reach dt.
  assign pre_sat = {21'd0, num[NUM_W-1:QUO_W]} >= dt;

  // One long-division step: bring down the next numerator bit and try a subtract.
  assign trial = {rem, low[QUO_W-1]};
  assign diff  = trial - {1'b0, dt};
  assign ge    = trial >= {1'b0, dt};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= start ? pre_sat : (busy && (cnt == '0));
      if (start) begin
        busy <= !pre_sat;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder, numerator and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      sat <= pre_sat;
      rem <= {21'd0, num[NUM_W-1:QUO_W]};
      low <= num[QUO_W-1:0];
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      low <= {low[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign stat.done = done;
  assign stat.sat  = sat;

endmodule

### rtl/pose_transform_velocity_estimator.sv
// Top level of the planar pose transform with finite-difference velocity.
//
// Each sample request (raw x, y, heading in degrees, timestamp in ms) is taken on
// sample_valid while sample_stall is low; one result request (global pose and
// velocities) follows on result_valid, held until result_stall is low.
// The block works on one sample at a time and stalls its input meanwhile. A single
// 33 by 33 bit multiplier forms the rotation, degree and time-scale products, and the
// pose is formed in states S_XC through S_FIN_H. One bit-serial divider then forms
// each of the three velocities in turn, or stops early on a channel whose quotient
// saturates. When a timestamp equals the previous one, the divider is skipped and the
// held velocities are reused; the next sample can be taken in the same cycle as the
// result request appears. The result sits in an output register, so the next sample
// is accepted while the receiver still stalls; the block waits only if it finishes a
// second result before the first is taken.
// Configuration writes via cfg_write, cfg_index and cfg_data take effect at once and
// are to be made by the user only while the block is idle; the block does not enforce
// this. Reset restores the identity rotation, zero offsets, a zero pose at time zero
// and zero held velocities.
module pose_transform_velocity_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] raw_x,
  input  logic signed [31:0] raw_y,
  input  logic signed [31:0] raw_heading_deg,
  input  logic [31:0]        sample_time_ms,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pose_heading,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_heading
);
  import ptve_pkg::*;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  state_t state, state_next;
  chan_t  ch;

  // Configuration registers.
  logic signed [31:0] cos_rotation, sin_rotation, x_offset, y_offset, heading_offset;

  // Stored pose, time and held velocities.
  logic signed [31:0] last_x, last_y, last_heading;
  logic [31:0]        last_time;
  logic signed [31:0] held_vel_x, held_vel_y, held_vel_heading;

  // Working registers of the current sample.
  logic signed [31:0] rx, ry, rdeg;
  logic [31:0]        now, dt;
  logic signed [65:0] prod, acc;
  logic signed [31:0] px, py, ph;
  logic [31:0]        mag;
  logic               neg;

  logic signed [32:0] op_a, op_b;
  logic               mul_en;
  logic               accept;
  logic               out_free;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  div_stat_t          div_stat;
  logic [QUO_W-1:0]   div_quo;
  logic signed [31:0] p_sel, l_sel;
  logic signed [32:0] delta;
  logic signed [31:0] vel_val;

  // Clamp a 37-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
    if ((&v[36:31]) || !(|v[36:31])) return v[31:0];
    return v[36] ? S32_MIN : S32_MAX;
  endfunction

  // Round a Q2.30 scaled product back to position format, add the offset, clamp.
  function automatic logic signed [31:0] fin30(input logic signed [65:0] v,
                                               input logic signed [31:0] off);
    logic [65:0] sum;
    sum = v + (66'd1 << 29);
    return sat37({sum[65], sum[65:30]} + {{5{off[31]}}, off});
  endfunction

  // Round the degree product by 2^32, add the heading offset, clamp.
  function automatic logic signed [31:0] fin32(input logic signed [65:0] v,
                                               input logic signed [31:0] off);
    logic [65:0] sum;
    sum = v + (66'd1 << 31);
    return sat37({{3{sum[65]}}, sum[65:32]} + {{5{off[31]}}, off});
  endfunction

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b0;
    case (state)
      S_XC: begin
        op_a = {rx[31], rx}; op_b = {cos_rotation[31], cos_rotation}; mul_en = 1'b1;
      end
      S_YS: begin
        op_a = {ry[31], ry}; op_b = {sin_rotation[31], sin_rotation}; mul_en = 1'b1;
      end
      S_XS: begin
        op_a = {rx[31], rx}; op_b = {sin_rotation[31], sin_rotation}; mul_en = 1'b1;
      end
      S_YC: begin
        op_a = {ry[31], ry}; op_b = {cos_rotation[31], cos_rotation}; mul_en = 1'b1;
      end
      S_DEG: begin
        op_a = {rdeg[31], rdeg}; op_b = DEG_TO_RAD_Q32; mul_en = 1'b1;
      end
      S_MUL: begin
        op_a = {1'b0, mag}; op_b = MS_PER_S; mul_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Pose and stored value of the channel whose velocity is being formed.
  always_comb begin
    case (ch)
      CH_X:    begin p_sel = px; l_sel = last_x;       end
      CH_Y:    begin p_sel = py; l_sel = last_y;       end
      CH_H:    begin p_sel = ph; l_sel = last_heading; end
      default: begin p_sel = px; l_sel = last_x;       end
    endcase
  end

  assign delta = {p_sel[31], p_sel} - {l_sel[31], l_sel};

  // Scaled magnitude plus half the elapsed time, so that the quotient rounds.
  assign div_num   = prod[NUM_W-1:0] + {11'd0, dt[31:1]};
  assign div_start = (state == S_NUM);

  // Signed, saturated velocity from the divider.
  always_comb begin
    if (div_stat.sat) vel_val = neg ? S32_MIN : S32_MAX;
    else if (neg)     vel_val = -$signed({1'b0, div_quo});
    else              vel_val = $signed({1'b0, div_quo});
  end

  ptve_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .dt    (dt),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_XC;
      S_XC:    state_next = S_YS;
      S_YS:    state_next = S_XS;
      S_XS:    state_next = S_YC;
      S_YC:    state_next = S_DEG;
      S_DEG:   state_next = S_FIN_Y;
      S_FIN_Y: state_next = S_FIN_H;
      S_FIN_H: state_next = (dt == '0) ? S_DONE : S_DIFF;
      S_DIFF:  state_next = S_MUL;
      S_MUL:   state_next = S_NUM;
      S_NUM:   state_next = S_WAIT;
      S_WAIT:  if (div_stat.done) state_next = (ch == CH_H) ? S_DONE : S_DIFF;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Configuration, stored pose, held velocities and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_rotation     <= 32'sh4000_0000;
      sin_rotation     <= '0;
      x_offset         <= '0;
      y_offset         <= '0;
      heading_offset   <= '0;
      last_x           <= '0;
      last_y           <= '0;
      last_heading     <= '0;
      last_time        <= '0;
      held_vel_x       <= '0;
      held_vel_y       <= '0;
      held_vel_heading <= '0;
      ch               <= CH_X;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COS:     cos_rotation   <= cfg_data;
          REG_SIN:     sin_rotation   <= cfg_data;
          REG_X_OFF:   x_offset       <= cfg_data;
          REG_Y_OFF:   y_offset       <= cfg_data;
          REG_HDG_OFF: heading_offset <= cfg_data;
          default: begin
          end
        endcase
      end
      // A new result is offered when one finishes; a stalled one stays offered.
      result_valid <= ((state == S_DONE) && out_free) || (result_valid && result_stall);
      case (state)
        S_FIN_H: ch <= CH_X;
        S_WAIT: begin
          if (div_stat.done) begin
            case (ch)
              CH_X:    begin held_vel_x <= vel_val;       ch <= CH_Y; end
              CH_Y:    begin held_vel_y <= vel_val;       ch <= CH_H; end
              CH_H:    begin held_vel_heading <= vel_val; ch <= CH_X; end
              default: ch <= CH_X;
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            last_x       <= px;
            last_y       <= py;
            last_heading <= ph;
            last_time    <= now;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers of the sample in work and the result register.
  always_ff @(posedge clk) begin
    if (mul_en) prod <= 66'(op_a * op_b);
    case (state)
      S_IDLE: begin
        if (accept) begin
          rx   <= raw_x;
          ry   <= raw_y;
          rdeg <= raw_heading_deg;
          now  <= sample_time_ms;
          dt   <= sample_time_ms - last_time;
        end
      end
      S_YS:    acc <= prod;
      S_XS:    acc <= acc - prod;
      S_YC: begin
        px  <= fin30(acc, x_offset);
        acc <= prod;
      end
      S_DEG:   acc <= acc + prod;
      S_FIN_Y: py <= fin30(acc, y_offset);
      S_FIN_H: ph <= fin32(prod, heading_offset);
      S_DIFF: begin
        neg <= delta[32];
        mag <= delta[32] ? 32'(-delta) : delta[31:0];
      end
      S_DONE: begin
        if (out_free) begin
          pos_x        <= px;
          pos_y        <= py;
          pose_heading <= ph;
          vel_x        <= held_vel_x;
          vel_y        <= held_vel_y;
          vel_heading  <= held_vel_heading;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/ptve_checker.sv
// Port-level assertions for the pose transform and velocity estimator, with their bind.
module ptve_checker (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] pose_heading,
  input logic signed [31:0] vel_x,
  input logic signed [31:0] vel_y,
  input logic signed [31:0] vel_heading
);

  // An accepted sample makes the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("sample input not stalled after a request was taken");

  // A new result only appears at the end of work on a sample.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result request appeared without work on a sample");

  // A stalled result stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("result request withdrawn while stalled");

  // A stalled result keeps its payload.
  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> ($stable(pos_x) && $stable(pos_y) &&
      $stable(pose_heading) && $stable(vel_x) && $stable(vel_y) && $stable(vel_heading)))
    else $error("result payload changed while stalled");

endmodule

bind pose_transform_velocity_estimator ptve_checker u_ptve_checker (.*);

### test/tb_pose_transform_velocity_estimator.sv
// Self-checking testbench for the pose transform and velocity estimator.
`timescale 1ns / 100ps

module tb_pose_transform_velocity_estimator;
  import ptve_pkg::*;

  // One pending sample request, with a flag that makes the sender wait for a quiet block.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] deg;
    logic [31:0]        stamp;
    bit                 drain;
  } sample_t;

  // One result request: global pose and velocities.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] hdg;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vh;
  } pose_t;

  typedef logic [5:0][31:0] pose_words_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = REG_COS;
  logic [31:0]        cfg_data = '0;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic signed [31:0] raw_x = '0;
  logic signed [31:0] raw_y = '0;
  logic signed [31:0] raw_heading_deg = '0;
  logic [31:0]        sample_time_ms = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pose_heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_heading;

  pose_transform_velocity_estimator u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .raw_x           (raw_x),
    .raw_y           (raw_y),
    .raw_heading_deg (raw_heading_deg),
    .sample_time_ms  (sample_time_ms),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pose_heading    (pose_heading),
    .vel_x           (vel_x),
    .vel_y           (vel_y),
    .vel_heading     (vel_heading)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic signed [31:0] rot_cos = 32'sh4000_0000;
  logic signed [31:0] rot_sin = '0;
  logic signed [31:0] off_x = '0;
  logic signed [31:0] off_y = '0;
  logic signed [31:0] off_hdg = '0;

  // Shadow copy of the stored pose and the held velocities.
  logic signed [31:0] last_x = '0;
  logic signed [31:0] last_y = '0;
  logic signed [31:0] last_hdg = '0;
  logic [31:0]        last_stamp = '0;
  logic signed [31:0] held_vx = '0;
  logic signed [31:0] held_vy = '0;
  logic signed [31:0] held_vh = '0;

  sample_t     pending_samples [$];
  pose_t       expected_poses [$];
  sample_t     next_sample;
  pose_t       wanted_pose;
  pose_words_t got_words;
  pose_words_t wanted_words;

  bit          sample_taken = 1'b0;
  bit          calm = 1'b0;
  int          mismatch_count = 0;
  int          samples_sent = 0;
  int          results_seen = 0;
  int          repeated_stamps = 0;
  int          settings_used = 1;

  // Generator state for well-formed trajectories.
  logic signed [31:0] gen_x = '0;
  logic signed [31:0] gen_y = '0;
  logic signed [31:0] gen_deg = '0;
  logic [31:0]        gen_stamp = '0;

  // Rounded arithmetic shift: ties go toward plus infinity.
  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Change per second from a change over dt milliseconds, rounded half away from zero.
  function automatic logic signed [31:0] per_second(longint delta, logic [31:0] dt);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (delta < 0) ? 64'(-delta) : 64'(delta);
    quo = (mag * 64'(MS_PER_S) + {33'd0, dt[31:1]}) / {32'd0, dt};
    if (delta < 0) return (quo >= 64'h8000_0000) ? 32'sh8000_0000 : -quo[31:0];
    return (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
  endfunction

  // Works out the pose and velocities for one sample and advances the shadow state.
  function automatic pose_t advance_pose(logic signed [31:0] rx, logic signed [31:0] ry,
                                         logic signed [31:0] deg, logic [31:0] stamp);
    pose_t       p;
    longint      gx;
    longint      gy;
    longint      rad;
    logic [31:0] dt;
    rad  = round_shift(longint'(deg) * longint'(DEG_TO_RAD_Q32), 32);
    gx   = round_shift(longint'(rx) * rot_cos - longint'(ry) * rot_sin, 30);
    gy   = round_shift(longint'(rx) * rot_sin + longint'(ry) * rot_cos, 30);
    p.x   = clamp32(gx + longint'(off_x));
    p.y   = clamp32(gy + longint'(off_y));
    p.hdg = clamp32(rad + longint'(off_hdg));
    dt = stamp - last_stamp;
    if (dt != 32'd0) begin
      held_vx = per_second(longint'(p.x) - longint'(last_x), dt);
      held_vy = per_second(longint'(p.y) - longint'(last_y), dt);
      held_vh = per_second(longint'(p.hdg) - longint'(last_hdg), dt);
    end else begin
      repeated_stamps++;
    end
    last_x     = p.x;
    last_y     = p.y;
    last_hdg   = p.hdg;
    last_stamp = stamp;
    p.vx = held_vx;
    p.vy = held_vy;
    p.vh = held_vh;
    return p;
  endfunction

  function automatic string field_name(int i);
    case (i)
      0: return "vel_heading";
      1: return "vel_y";
      2: return "vel_x";
      3: return "pose_heading";
      4: return "pos_y";
      default: return "pos_x";
    endcase
  endfunction

  function automatic void flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $time, what);
  endfunction

  // Sender: a new request goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      if (pending_samples.size() == 0 || (!calm && $urandom_range(99) < 24) ||
          (pending_samples[0].drain && expected_poses.size() != 0)) begin
        sample_valid <= 1'b0;
      end else begin
        next_sample = pending_samples.pop_front();
        raw_x           <= next_sample.x;
        raw_y           <= next_sample.y;
        raw_heading_deg <= next_sample.deg;
        sample_time_ms  <= next_sample.stamp;
        sample_valid    <= 1'b1;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  // Monitor: predict on each accepted sample, check each accepted result.
  always @(posedge clk) begin
    sample_taken <= sample_valid && !sample_stall;
    if (!rst && sample_valid && !sample_stall) begin
      expected_poses.push_back(advance_pose(raw_x, raw_y, raw_heading_deg, sample_time_ms));
      samples_sent++;
    end
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_poses.size() == 0) begin
        flag_mismatch("result arrived with no sample outstanding");
      end else begin
        wanted_pose  = expected_poses.pop_front();
        wanted_words = wanted_pose;
        got_words    = {pos_x, pos_y, pose_heading, vel_x, vel_y, vel_heading};
        for (int i = 0; i < 6; i++) begin
          if (got_words[i] !== wanted_words[i])
            flag_mismatch($sformatf("result %0d %s: expected %0d, got %0d", results_seen,
                                    field_name(i), $signed(wanted_words[i]),
                                    $signed(got_words[i])));
        end
      end
    end
  end

  task automatic add_sample(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] deg, logic [31:0] stamp, bit drain);
    sample_t s;
    s.x     = x;
    s.y     = y;
    s.deg   = deg;
    s.stamp = stamp;
    s.drain = drain;
    pending_samples.push_back(s);
  endtask

  // Register write; the shadow copy follows the block's decode.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_COS:     rot_cos = val;
      REG_SIN:     rot_sin = val;
      REG_X_OFF:   off_x = val;
      REG_Y_OFF:   off_y = val;
      REG_HDG_OFF: off_hdg = val;
      default:     ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_setting(logic [31:0] c, logic [31:0] s, logic [31:0] ox,
                               logic [31:0] oy, logic [31:0] oh);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    write_reg(REG_X_OFF, ox);
    write_reg(REG_Y_OFF, oy);
    write_reg(REG_HDG_OFF, oh);
    settings_used++;
  endtask

  // Waits until every request has been sent and every result has come back.
  task automatic settle();
    while (pending_samples.size() != 0 || sample_valid || expected_poses.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [31:0] jitter();
    return $signed($urandom) >>> $urandom_range(31, 10);
  endfunction

  // Mostly smooth trajectories with small time steps, some repeats, jumps and noise.
  task automatic queue_random(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        gen_x     = $urandom;
        gen_y     = $urandom;
        gen_deg   = $urandom;
        gen_stamp = $urandom;
      end else begin
        gen_x   = gen_x + jitter();
        gen_y   = gen_y + jitter();
        gen_deg = gen_deg + jitter();
        if (kind >= 16) begin
          if (kind < 20) gen_stamp = gen_stamp + $urandom;
          else gen_stamp = gen_stamp + $urandom_range(40, 1);
        end
      end
      add_sample(gen_x, gen_y, gen_deg, gen_stamp, $urandom_range(99) == 0);
    end
  endtask

  function automatic logic [31:0] any_trig();
    return $urandom_range(32'h8000_0000) - 32'h4000_0000;
  endfunction

  function automatic logic [31:0] corner_trig();
    return $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
  endfunction

  function automatic logic [31:0] corner_offset();
    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: first sample against the zero pose, repeated stamp,
    // saturating velocities, timestamp wrap and rounding ties.
    add_sample(32'sd65536, 32'sd131072, 32'sd90 <<< 16, 32'd10, 1'b0);
    add_sample(32'sd196608, -32'sd65536, -(32'sd45 <<< 16), 32'd10, 1'b0);
    add_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd11, 1'b0);
    add_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'd12, 1'b0);
    add_sample(32'sd0, 32'sd0, 32'sd0, 32'hFFFF_FFF0, 1'b0);
    add_sample(32'sd1, -32'sd1, 32'sd180 <<< 16, 32'h0000_0010, 1'b0);
    add_sample(32'sd2, -32'sd2, 32'sd180 <<< 16, 32'h0000_0010 + 32'd2000, 1'b0);
    add_sample(32'sd2, -32'sd2, 32'sd0, 32'hFFFF_FFFF, 1'b0);
    add_sample(-32'sd65536, 32'sd65536, 32'sd360 <<< 16, 32'hFFFF_FFFF, 1'b1);
    add_sample(32'sd0, 32'sd0, -(32'sd360 <<< 16), 32'd0, 1'b0);
    settle();

    // Extreme rotation and offsets, plus writes to indexes the block does not decode.
    write_setting(32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF);
    for (int i = REG_HDG_OFF + 1; i < 8; i++) write_reg(3'(i), $urandom);
    add_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd100, 1'b0);
    add_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd200, 1'b0);
    add_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'd200, 1'b0);
    add_sample(32'sd65536, -32'sd65536, 32'sd90 <<< 16, 32'd300, 1'b0);
    add_sample(32'sd0, 32'sd0, 32'sd0, 32'd301, 1'b0);
    settle();

    // Non-unit rotation with opposite offsets.
    write_setting(32'h4000_0000, 32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000);
    add_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'd400, 1'b0);
    add_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd401, 1'b0);
    add_sample(-32'sd65536, -32'sd65536, -(32'sd90 <<< 16), 32'd500, 1'b0);
    add_sample(32'sd0, 32'sd0, 32'sd0, 32'd500, 1'b0);
    add_sample(32'sh8000_0000, 32'sh8000_0000, 32'sd0, 32'd0, 1'b0);
    settle();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_setting(32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
        1: write_setting(any_trig(), any_trig(), $urandom, $urandom, $urandom);
        2: write_setting(corner_trig(), corner_trig(), corner_offset(), corner_offset(),
                         corner_offset());
        3: write_setting(32'd0, 32'd0, jitter(), jitter(), jitter());
        default: write_setting(any_trig(), any_trig(), jitter(), jitter(), $urandom);
      endcase
      calm <= (phase == 2);
      queue_random(220);
      settle();
    end
    calm <= 1'b0;

    repeat (150) @(negedge clk);
    $display("Covered %0d samples under %0d register settings, %0d with an unchanged stamp.",
             samples_sent, settings_used, repeated_stamps);
    $display("Compared %0d results; %0d field mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_600_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
